// File: src/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and lookup tables shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned DfaW  = 4;
  localparam int unsigned ClsW  = 4;
  localparam int unsigned CodeW = 21;

  // DFA states with a fixed meaning; 2..8 are pending states
  localparam logic [DfaW-1:0] ST_ACCEPT  = 4'd0;
  localparam logic [DfaW-1:0] ST_REJECT  = 4'd1;
  localparam logic [DfaW-1:0] ST_LAST    = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } utf8d_req_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             complete;
    logic             malformed;
    logic [DfaW-1:0]  dfa_now;
  } utf8d_rsp_t;

  // Transition table: row = state (9 rows), column = byte class (16, 12 used)
  localparam logic [DfaW-1:0] NEXT_STATE [144] = '{
    4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
  };

  // Byte class lookup (256-entry table written as ranges)
  function automatic logic [ClsW-1:0] byte_class(input logic [7:0] b);
    logic [ClsW-1:0] cls;
    unique case (b) inside
      [8'h00:8'h7F]: cls = 4'd0;   // ASCII
      [8'h80:8'h8F]: cls = 4'd1;
      [8'h90:8'h9F]: cls = 4'd9;
      [8'hA0:8'hBF]: cls = 4'd7;
      [8'hC0:8'hC1]: cls = 4'd8;   // overlong two-byte leads
      [8'hC2:8'hDF]: cls = 4'd2;
      8'hE0:         cls = 4'd10;
      [8'hE1:8'hEC]: cls = 4'd3;
      8'hED:         cls = 4'd4;   // surrogate range lead
      [8'hEE:8'hEF]: cls = 4'd3;
      8'hF0:         cls = 4'd11;
      [8'hF1:8'hF3]: cls = 4'd6;
      8'hF4:         cls = 4'd5;
      default:       cls = 4'd8;   // F5..FF never valid
    endcase
    return cls;
  endfunction

endpackage

// File: src/utf8d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_core
// Decoder state (DFA state and partial code point) and the one-byte step.
// ----------------------------------------------------------------------------
module utf8d_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  utf8d_pkg::utf8d_req_t req_i,
  output utf8d_pkg::utf8d_rsp_t rsp_o
);
  import utf8d_pkg::*;

  logic [DfaW-1:0]  state_q, state_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [DfaW-1:0]  cur_state;
  logic [ClsW-1:0]  cls;
  logic [7:0]       lead_mask;

  // restart forces accept; out-of-range states behave as reject
  always_comb begin
    if (req_i.restart) begin
      cur_state = ST_ACCEPT;
    end else if (state_q > ST_LAST) begin
      cur_state = ST_REJECT;
    end else begin
      cur_state = state_q;
    end
  end

  assign cls       = byte_class(req_i.data_byte);
  assign lead_mask = 8'hFF >> cls;

  // accumulate: lead byte payload, or shift in six continuation bits
  always_comb begin
    if (cur_state == ST_ACCEPT) begin
      code_d = {{(CodeW-8){1'b0}}, req_i.data_byte & lead_mask};
    end else begin
      code_d = {code_q[CodeW-7:0], req_i.data_byte[5:0]};
    end
    state_d = NEXT_STATE[{cur_state, cls}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
      code_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  // result of this step
  assign rsp_o.code_point = code_d;
  assign rsp_o.complete   = (state_d == ST_ACCEPT);
  assign rsp_o.malformed  = (state_d == ST_REJECT);
  assign rsp_o.dfa_now    = state_d;

  // state register only ever holds one of the nine table states
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= ST_LAST)
    else $error("DFA state out of range");

  // reject only leaves on restart
  a_reject_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !req_i.restart && state_q == ST_REJECT) |=> state_q == ST_REJECT)
    else $error("reject state left without restart");

  // continuation step shifts the low six bits of the byte in
  a_cont_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !req_i.restart && state_q != ST_ACCEPT)
      |=> code_q[5:0] == $past(req_i.data_byte[5:0]))
    else $error("continuation bits not accumulated");

  // without a step the DFA state and the partial code hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(state_q) && $stable(code_q)))
    else $error("decoder state changed without a step");

endmodule

// File: src/utf8_dfa_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dfa_decoder_top
// UTF-8 byte-stream decoder with valid/ready request and result channels.
// ----------------------------------------------------------------------------
// The decoder takes one byte request per clock cycle, unless the result
// side holds back (out_ready_i low with a result waiting), and returns exactly
// one result per byte, in order. A request is captured in an input register;
// when the result register is free (or being drained) the byte is classified,
// the DFA steps and the result is registered. The DFA state and partial code
// point are reset to accept and zero; no clearing pass is needed. Reject is
// sticky until a request with restart set.
module utf8_dfa_decoder_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  utf8d_pkg::utf8d_req_t in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8d_pkg::utf8d_rsp_t out_rsp_o
);
  import utf8d_pkg::*;

  logic       in_valid_q;
  utf8d_req_t in_req_q;
  logic       out_valid_q;
  utf8d_rsp_t out_rsp_q;
  utf8d_rsp_t step_rsp;
  logic       advance;

  // move the held request into the result register when it is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  utf8d_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_req_q),
    .rsp_o  (step_rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: sim/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches the request and result channels of the UTF-8 decoder, predicts
// each result from its own copy of the DFA state and the partial code point,
// and compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  utf8d_pkg::utf8d_req_t req_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  utf8d_pkg::utf8d_rsp_t rsp_i,
  output int                    err_count_o,
  output int                    pending_o
);
  import utf8d_pkg::*;

  // Byte classes; the value doubles as the lead-byte mask shift
  localparam logic [3:0] CLS_ASCII    = 4'd0;
  localparam logic [3:0] CLS_CONT_LO  = 4'd1;   // 80..8F
  localparam logic [3:0] CLS_LEAD2    = 4'd2;   // C2..DF
  localparam logic [3:0] CLS_LEAD3    = 4'd3;   // E1..EC, EE..EF
  localparam logic [3:0] CLS_LEAD_ED  = 4'd4;
  localparam logic [3:0] CLS_LEAD_F4  = 4'd5;
  localparam logic [3:0] CLS_LEAD4    = 4'd6;   // F1..F3
  localparam logic [3:0] CLS_CONT_HI  = 4'd7;   // A0..BF
  localparam logic [3:0] CLS_INVALID  = 4'd8;   // C0, C1, F5..FF
  localparam logic [3:0] CLS_CONT_MID = 4'd9;   // 90..9F
  localparam logic [3:0] CLS_LEAD_E0  = 4'd10;
  localparam logic [3:0] CLS_LEAD_F0  = 4'd11;

  // Pending states, named by what the next byte must be
  localparam logic [3:0] ST_NEED1 = 4'd2;
  localparam logic [3:0] ST_NEED2 = 4'd3;
  localparam logic [3:0] ST_AFTER_E0 = 4'd4;
  localparam logic [3:0] ST_AFTER_ED = 4'd5;
  localparam logic [3:0] ST_AFTER_F0 = 4'd6;
  localparam logic [3:0] ST_NEED3 = 4'd7;
  localparam logic [3:0] ST_AFTER_F4 = 4'd8;

  logic [3:0]       dfa_q;
  logic [CodeW-1:0] code_q;
  utf8d_rsp_t       scalar_q[$];
  int               mismatches;

  // Steps the decoder by one byte and returns the result it must produce
  function automatic utf8d_rsp_t decode_byte(input utf8d_req_t req);
    logic [3:0] cls;
    logic [3:0] st;
    logic       lo, mid, hi;
    utf8d_rsp_t rsp;
    st = req.restart ? ST_ACCEPT : dfa_q;
    if (req.data_byte < 8'h80)       cls = CLS_ASCII;
    else if (req.data_byte < 8'h90)  cls = CLS_CONT_LO;
    else if (req.data_byte < 8'hA0)  cls = CLS_CONT_MID;
    else if (req.data_byte < 8'hC0)  cls = CLS_CONT_HI;
    else if (req.data_byte < 8'hC2)  cls = CLS_INVALID;
    else if (req.data_byte < 8'hE0)  cls = CLS_LEAD2;
    else if (req.data_byte == 8'hE0) cls = CLS_LEAD_E0;
    else if (req.data_byte == 8'hED) cls = CLS_LEAD_ED;
    else if (req.data_byte < 8'hF0)  cls = CLS_LEAD3;
    else if (req.data_byte == 8'hF0) cls = CLS_LEAD_F0;
    else if (req.data_byte < 8'hF4)  cls = CLS_LEAD4;
    else if (req.data_byte == 8'hF4) cls = CLS_LEAD_F4;
    else                             cls = CLS_INVALID;
    lo  = (cls == CLS_CONT_LO);
    mid = (cls == CLS_CONT_MID);
    hi  = (cls == CLS_CONT_HI);

    // lead byte keeps its payload bits, continuation shifts in six more
    if (st == ST_ACCEPT) begin
      code_q = {13'd0, req.data_byte & (8'hFF >> cls)};
    end else begin
      code_q = {code_q[CodeW-7:0], req.data_byte[5:0]};
    end

    dfa_q = ST_REJECT;
    case (st)
      ST_ACCEPT: begin
        case (cls)
          CLS_ASCII:   dfa_q = ST_ACCEPT;
          CLS_LEAD2:   dfa_q = ST_NEED1;
          CLS_LEAD3:   dfa_q = ST_NEED2;
          CLS_LEAD_E0: dfa_q = ST_AFTER_E0;
          CLS_LEAD_ED: dfa_q = ST_AFTER_ED;
          CLS_LEAD_F0: dfa_q = ST_AFTER_F0;
          CLS_LEAD4:   dfa_q = ST_NEED3;
          CLS_LEAD_F4: dfa_q = ST_AFTER_F4;
          default:     dfa_q = ST_REJECT;
        endcase
      end
      ST_NEED1:    if (lo || mid || hi) dfa_q = ST_ACCEPT;
      ST_NEED2:    if (lo || mid || hi) dfa_q = ST_NEED1;
      ST_AFTER_E0: if (hi) dfa_q = ST_NEED1;          // no overlong 3-byte
      ST_AFTER_ED: if (lo || mid) dfa_q = ST_NEED1;   // no surrogates
      ST_AFTER_F0: if (mid || hi) dfa_q = ST_NEED2;   // no overlong 4-byte
      ST_NEED3:    if (lo || mid || hi) dfa_q = ST_NEED2;
      ST_AFTER_F4: if (lo) dfa_q = ST_NEED2;          // nothing above 10FFFF
      default:     dfa_q = ST_REJECT;                 // reject is sticky
    endcase

    rsp.code_point = code_q;
    rsp.complete   = (dfa_q == ST_ACCEPT);
    rsp.malformed  = (dfa_q == ST_REJECT);
    rsp.dfa_now    = dfa_q;
    return rsp;
  endfunction

  // Compare the result first, then predict from the request of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    utf8d_rsp_t want;
    if (!rst_ni) begin
      dfa_q       = ST_ACCEPT;
      code_q      = '0;
      mismatches  = 0;
      scalar_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (scalar_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing pending: cp=%h c=%b m=%b st=%0d",
                     $realtime, rsp_i.code_point, rsp_i.complete, rsp_i.malformed,
                     rsp_i.dfa_now);
          end
          mismatches++;
        end else begin
          want = scalar_q.pop_front();
          if (rsp_i.code_point !== want.code_point || rsp_i.complete !== want.complete ||
              rsp_i.malformed !== want.malformed || rsp_i.dfa_now !== want.dfa_now) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch exp cp=%h c=%b m=%b st=%0d got cp=%h c=%b m=%b st=%0d",
                       $realtime, want.code_point, want.complete, want.malformed,
                       want.dfa_now, rsp_i.code_point, rsp_i.complete, rsp_i.malformed,
                       rsp_i.dfa_now);
            end
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        scalar_q.push_back(decode_byte(req_i));
      end
      err_count_o <= mismatches;
      pending_o   <= scalar_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the UTF-8 decoder: a directed set of boundary code points and
// malformed forms, then random well-formed characters mixed with broken
// sequences, run under four phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  import utf8d_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int ItemsPerPhase = 306;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  utf8d_req_t in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  utf8d_rsp_t out_rsp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_count = 0;
  int quiet_cycles = 0;
  int fail_count;
  int scalars_pending;
  logic resync;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  utf8_dfa_decoder_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  utf8_decode_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (in_valid),
    .req_ready_i (in_ready),
    .req_i       (in_req),
    .rsp_valid_i (out_valid),
    .rsp_ready_i (out_ready),
    .rsp_i       (out_rsp),
    .err_count_o (fail_count),
    .pending_o   (scalars_pending)
  );

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles with no request and no result accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One request, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req.data_byte <= b;
    in_req.restart   <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Well-formed encoding of one scalar value
  task automatic send_scalar(input logic [20:0] cp, input logic rs);
    if (cp < 21'h80) begin
      send_byte(cp[7:0], rs);
    end else if (cp < 21'h800) begin
      send_byte({3'b110, cp[10:6]}, rs);
      send_byte({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 21'h10000) begin
      send_byte({4'b1110, cp[15:12]}, rs);
      send_byte({2'b10, cp[11:6]}, 1'b0);
      send_byte({2'b10, cp[5:0]}, 1'b0);
    end else begin
      send_byte({5'b11110, cp[20:18]}, rs);
      send_byte({2'b10, cp[17:12]}, 1'b0);
      send_byte({2'b10, cp[11:6]}, 1'b0);
      send_byte({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  function automatic logic [20:0] random_scalar();
    logic [20:0] cp;
    case ($urandom_range(3))
      0: cp = 21'($urandom_range(8'h7F, 0));
      1: cp = 21'($urandom_range(11'h7FF, 8'h80));
      2: begin
        cp = 21'($urandom_range(16'hFFFF, 12'h800));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;  // skip surrogates
      end
      default: cp = 21'($urandom_range(21'h10FFFF, 17'h10000));
    endcase
    return cp;
  endfunction

  // Malformed or noisy input of several kinds
  task automatic send_broken();
    case ($urandom_range(5))
      0: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      1: begin  // truncated: lead byte then ASCII
        send_byte(8'($urandom_range(8'hF4, 8'hC2)), 1'b0);
        send_byte(8'($urandom_range(8'h7F)), 1'b0);
      end
      2: begin  // overlong forms
        case ($urandom_range(2))
          0: send_byte(8'($urandom_range(8'hC1, 8'hC0)), 1'b0);
          1: begin
            send_byte(8'hE0, 1'b0);
            send_byte(8'($urandom_range(8'h9F, 8'h80)), 1'b0);
          end
          default: begin
            send_byte(8'hF0, 1'b0);
            send_byte(8'($urandom_range(8'h8F, 8'h80)), 1'b0);
          end
        endcase
        send_byte(8'($urandom_range(8'hBF, 8'h80)), 1'b0);
      end
      3: begin  // surrogate
        send_byte(8'hED, 1'b0);
        send_byte(8'($urandom_range(8'hBF, 8'hA0)), 1'b0);
        send_byte(8'($urandom_range(8'hBF, 8'h80)), 1'b0);
      end
      4: begin  // above 10FFFF
        if ($urandom_range(1) != 0) begin
          send_byte(8'hF4, 1'b0);
          send_byte(8'($urandom_range(8'hBF, 8'h90)), 1'b0);
        end else begin
          send_byte(8'($urandom_range(8'hFF, 8'hF5)), 1'b0);
        end
      end
      default: send_byte(8'($urandom_range(8'hBF, 8'h80)), 1'b0);  // stray continuation
    endcase
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 85, 0, 25};
    stall_set = '{0, 0, 85, 25};
    resync = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Boundary values of each encoding length
    send_scalar(21'h0, 1'b1);
    send_scalar(21'h7F, 1'b0);
    send_scalar(21'h80, 1'b0);
    send_scalar(21'h800, 1'b0);
    send_scalar(21'hD7FF, 1'b0);
    send_scalar(21'h10000, 1'b0);
    send_scalar(21'h10FFFF, 1'b0);
    // overlong lead, then reject holds without restart
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    // surrogate, above the last scalar, invalid lead
    send_byte(8'hED, 1'b1);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hF4, 1'b1);
    send_byte(8'h90, 1'b0);
    send_byte(8'hFF, 1'b1);
    // restart in the middle of a sequence, then a stray continuation
    send_byte(8'hE1, 1'b1);
    send_byte(8'h41, 1'b1);
    send_byte(8'hBF, 1'b0);
    resync = 1'b1;

    // Random part, one block per idling phase
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      while (sent_count < 28 + (p + 1) * ItemsPerPhase) begin
        if ($urandom_range(99) < 78) begin
          send_scalar(random_scalar(), resync || ($urandom_range(7) == 0));
          resync = 1'b0;
        end else begin
          send_broken();
          resync = 1'b1;
        end
      end
    end

    // Drain remaining results
    in_valid <= 1'b0;
    @(posedge clk);
    while (scalars_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
src/utf8d_pkg.sv
src/utf8d_core.sv
src/utf8_dfa_decoder_top.sv
sim/utf8_decode_checker.sv
sim/tb_top.sv
